// File: sv/top5_peak_centroid_core_defines.svh
// ----------------------------------------------------------------------------
// top5_peak_centroid_core_defines
// Assertion macros used by the checker of the peak centroid core.
// ----------------------------------------------------------------------------
`ifndef TOP5_PEAK_CENTROID_CORE_DEFINES_SVH
`define TOP5_PEAK_CENTROID_CORE_DEFINES_SVH

// same-cycle implication
`define T5_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define T5_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/top5pc_pkg.sv
// ----------------------------------------------------------------------------
// top5pc_pkg
// Types and constants of the top-five peak centroid core.
// ----------------------------------------------------------------------------
`default_nettype none

package top5pc_pkg;

	localparam int IDX_W    = 16;
	localparam int SAMP_W   = 16;
	localparam int TOPK     = 5;
	localparam int CNT_W    = IDX_W + 1;
	localparam int HELD_W   = $clog2(TOPK + 1);
	localparam int POS_W    = $clog2(TOPK);
	localparam int SUM_W    = IDX_W + 3;
	localparam int VALL_W   = SAMP_W + 3;
	localparam int OUT_W    = 18;
	localparam int ST_W     = 2;
	localparam int TDATA_W  = ((2 * OUT_W + 7) / 8) * 8;
	localparam int STDATA_W = ((SAMP_W + 7) / 8) * 8;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	typedef logic signed [SAMP_W-1:0] samp_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [ST_W-1:0]          status_t;
	typedef logic signed [VALL_W-1:0] vall_t;
	typedef logic [SUM_W-1:0]         isum_t;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_FEW  = 2'd1;
	localparam status_t ST_LONG = 2'd2;

	typedef struct packed {
		samp_t [TOPK-1:0] vals;
		idx_t  [TOPK-1:0] idxs;
		status_t          status;
	} snap_t;

endpackage

`default_nettype wire

// File: sv/top5pc_front.sv
// ----------------------------------------------------------------------------
// top5pc_front
// Accepts samples, keeps the ranked top five and hands a snapshot per trace.
// ----------------------------------------------------------------------------
`default_nettype none

module top5pc_front import top5pc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  samp_t in_sample,
	input  logic  in_last,
	output logic  push,
	output snap_t push_data,
	input  logic  q_full
);

	samp_t             vals_q [TOPK];
	idx_t              idxs_q [TOPK];
	logic [HELD_W-1:0] held_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              ovf_q;

	logic              acc;
	logic              room;
	idx_t              new_idx;
	logic [TOPK-1:0]   gt;
	samp_t             ins_v [TOPK];
	idx_t              ins_i [TOPK];
	logic [HELD_W-1:0] held_n;
	logic [HELD_W-1:0] held_after;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign room     = !cnt_q[IDX_W];
	assign new_idx  = cnt_q[IDX_W-1:0];
	assign held_n   = (held_q < HELD_W'(TOPK)) ? held_q + HELD_W'(1) : held_q;
	assign held_after = room ? held_n : held_q;

	always_comb begin
		for (int i = 0; i < TOPK; i++) begin
			gt[i] = (HELD_W'(i) < held_q) && (vals_q[i] > in_sample);
		end
	end

	always_comb begin
		ins_v[0] = gt[0] ? vals_q[0] : in_sample;
		ins_i[0] = gt[0] ? idxs_q[0] : new_idx;
		for (int i = 1; i < TOPK; i++) begin
			if (gt[i]) begin
				ins_v[i] = vals_q[i];
				ins_i[i] = idxs_q[i];
			end else if (gt[i-1]) begin
				ins_v[i] = in_sample;
				ins_i[i] = new_idx;
			end else begin
				ins_v[i] = vals_q[i-1];
				ins_i[i] = idxs_q[i-1];
			end
		end
	end

	always_comb begin
		push = acc && in_last;
		for (int i = 0; i < TOPK; i++) begin
			push_data.vals[i] = room ? ins_v[i] : vals_q[i];
			push_data.idxs[i] = room ? ins_i[i] : idxs_q[i];
		end
		if (ovf_q || !room) begin
			push_data.status = ST_LONG;
		end else if (held_after < HELD_W'(TOPK)) begin
			push_data.status = ST_FEW;
		end else begin
			push_data.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (acc) begin
			if (in_last) begin
				held_q <= '0;
				cnt_q  <= '0;
				ovf_q  <= 1'b0;
			end else if (room) begin
				held_q <= held_n;
				cnt_q  <= cnt_q + CNT_W'(1);
			end else begin
				ovf_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !in_last && room) begin
			for (int i = 0; i < TOPK; i++) begin
				vals_q[i] <= ins_v[i];
				idxs_q[i] <= ins_i[i];
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/top5pc_queue.sv
// ----------------------------------------------------------------------------
// top5pc_queue
// Short snapshot queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module top5pc_queue import top5pc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  snap_t push_data,
	output logic  full,
	output logic  out_valid,
	input  logic  out_ready,
	output snap_t out_data
);

	snap_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              wr;
	logic              rd;

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rptr_q];
	assign wr        = push && !full;
	assign rd        = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (rd) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: sv/top5pc_back.sv
// ----------------------------------------------------------------------------
// top5pc_back
// Sums, picks the outlier to drop and forms the trimmed centroid result (zero sums unless status is OK).
// ----------------------------------------------------------------------------
`default_nettype none

module top5pc_back import top5pc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  snap_t            in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] value_sum_four,
	output logic [OUT_W-1:0] index_sum_four,
	output status_t          status
);

	logic             en;
	logic             v_s1;
	snap_t            snap_s1;
	isum_t            total_s1;
	vall_t            vall_s1;
	logic             v_s2;
	snap_t            snap_s2;
	isum_t            total_s2;
	vall_t            vall_s2;
	logic [POS_W-1:0] drop_s2;
	logic             out_valid_q;
	logic [OUT_W-1:0] vsum_q;
	logic [OUT_W-1:0] isum_q;
	status_t          status_q;

	isum_t            total_c;
	vall_t            vall_c;
	isum_t            s5;
	isum_t            spread;
	isum_t            best;
	logic [POS_W-1:0] drop_c;
	vall_t            vsum_c;
	isum_t            isum_c;

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign out_valid = out_valid_q;
	assign value_sum_four = vsum_q;
	assign index_sum_four = isum_q;
	assign status    = status_q;

	always_comb begin
		total_c = '0;
		vall_c  = '0;
		for (int i = 0; i < TOPK; i++) begin
			total_c = total_c + SUM_W'(in_data.idxs[i]);
			vall_c  = vall_c + VALL_W'($signed(in_data.vals[i]));
		end
	end

	always_comb begin
		best   = '0;
		drop_c = '0;
		s5     = '0;
		spread = '0;
		for (int i = 0; i < TOPK; i++) begin
			s5     = (SUM_W'(snap_s1.idxs[i]) << 2) + SUM_W'(snap_s1.idxs[i]);
			spread = (s5 >= total_s1) ? s5 - total_s1 : total_s1 - s5;
			if (i == 0 || spread > best) begin
				best   = spread;
				drop_c = POS_W'(i);
			end
		end
	end

	always_comb begin
		vsum_c = vall_s2 - VALL_W'($signed(snap_s2.vals[drop_s2]));
		isum_c = total_s2 - SUM_W'(snap_s2.idxs[drop_s2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			snap_s1  <= in_data;
			total_s1 <= total_c;
			vall_s1  <= vall_c;
			snap_s2  <= snap_s1;
			total_s2 <= total_s1;
			vall_s2  <= vall_s1;
			drop_s2  <= drop_c;
			status_q <= snap_s2.status;
			if (snap_s2.status == ST_OK) begin
				vsum_q <= vsum_c[OUT_W-1:0];
				isum_q <= isum_c[OUT_W-1:0];
			end else begin
				vsum_q <= '0;
				isum_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/top5_peak_centroid_core.sv
// ----------------------------------------------------------------------------
// top5_peak_centroid_core
// Running top-five sample selection with an outlier-trimmed centroid.
//
//   channel | dir | tdata                          | tuser  | tlast
//   s_*     | in  | sample[15:0]                   | -      | last_sample
//   m_*     | out | value_sum_four, index_sum_four | status | -
//
// One sample per cycle while s_tready is high; the parallel five-entry compare insert sets that rate.
// The edge that accepts the last sample of a trace writes its snapshot to the queue;
// the result then passes the sum stage, drop select stage and output register.
// Reset is asynchronous and clears counts and valid flags; nothing is swept.
// s_tready drops only while the two-entry snapshot queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module top5_peak_centroid_core import top5pc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [STDATA_W-1:0] s_tdata,  // sample
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [TDATA_W-1:0]  m_tdata,  // value_sum_four, index_sum_four, zeros
	output logic [ST_W-1:0]     m_tuser   // status
);

	logic             push;
	snap_t            push_data;
	logic             q_full;
	logic             q_valid;
	logic             q_ready;
	snap_t            q_data;
	logic [OUT_W-1:0] value_sum_four;
	logic [OUT_W-1:0] index_sum_four;

	top5pc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_sample (samp_t'(s_tdata[SAMP_W-1:0])),
		.in_last   (s_tlast),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	top5pc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_data)
	);

	top5pc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (q_valid),
		.in_ready       (q_ready),
		.in_data        (q_data),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.value_sum_four (value_sum_four),
		.index_sum_four (index_sum_four),
		.status         (m_tuser)
	);

	assign m_tdata = {(TDATA_W - 2 * OUT_W)'(0), index_sum_four, value_sum_four};

endmodule

`default_nettype wire

// File: sv/top5pc_checker.sv
// ----------------------------------------------------------------------------
// top5pc_checker
// Port-level checks of the peak centroid core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "top5_peak_centroid_core_defines.svh"

module top5pc_checker import top5pc_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic [STDATA_W-1:0] s_tdata,
	input wire logic                s_tlast,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [TDATA_W-1:0]  m_tdata,
	input wire logic [ST_W-1:0]     m_tuser
);

	`T5_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	`T5_ASSERT_NOW(a_err_zero, clk, arst_n, m_tvalid && (m_tuser != ST_OK), m_tdata == '0, "error result carries nonzero sums")
	`T5_ASSERT_NOW(a_isum_min, clk, arst_n, m_tvalid && (m_tuser == ST_OK), m_tdata[2*OUT_W-1:OUT_W] >= OUT_W'(6), "index sum below four distinct indices")
	`T5_ASSERT_NOW(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[TDATA_W-1:2*OUT_W] == '0, "tdata padding not zero")

endmodule

bind top5_peak_centroid_core top5pc_checker u_chk (.*);

`default_nettype wire
